// ===== src/tln_pkg.sv =====
`default_nettype none
package tln_pkg;

  localparam int COL_BITS = 16;
  localparam int RUN_W = 16;
  localparam int BYTE_W = 8;
  localparam int SLOTS = 4;

  typedef logic [COL_BITS-1:0] col_t;
  typedef logic [RUN_W-1:0] run_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam col_t COL_MAX = '1;
  localparam run_t RUN_MAX = '1;
  localparam run_t RUN_ONE = run_t'(1);

  localparam byte_t CH_EOF = 8'h1A;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_CR = 8'h0D;
  localparam byte_t CH_LF = 8'h0A;
  localparam byte_t CH_SP = 8'h20;

  typedef enum logic [1:0] {
    CFG_INSERT_CR    = 2'd0,
    CFG_COMPRESS_TABS = 2'd1,
    CFG_ENSURE_EOF   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    run_t  run;
    byte_t data;
  } slot_t;

  // Up to four results of one item, in output order; a clear valid bit skips a slot.
  typedef struct packed {
    logic [SLOTS-1:0] valid;
    slot_t [SLOTS-1:0] slot;
  } batch_t;

  function automatic run_t sat_run(input col_t v);
    logic [COL_BITS+RUN_W-1:0] wide;
    wide = (COL_BITS+RUN_W)'(v);
    if (wide > (COL_BITS+RUN_W)'(RUN_MAX)) begin
      return RUN_MAX;
    end
    return RUN_W'(wide);
  endfunction

  function automatic col_t inc_sat(input col_t v);
    return (v == COL_MAX) ? v : v + col_t'(1);
  endfunction

endpackage
`default_nettype wire

// ===== src/tln_emit.sv =====
`default_nettype none
module tln_emit
  import tln_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire batch_t batch,
  output logic        free,
  output logic        out_tvalid,
  input  wire logic   out_tready,
  output logic [23:0] out_tdata,   // out_byte [7:0], run_length [23:8]
  output logic        out_tlast
);

  logic [SLOTS-1:0] mask_r, mask_nxt;
  slot_t [SLOTS-1:0] slot_r;
  logic [SLOTS-1:0] sel;
  slot_t cur;
  logic take;

  // Lowest pending slot goes out first.
  always_comb begin
    sel = '0;
    cur = slot_r[0];
    if (mask_r[0]) begin
      sel[0] = 1'b1;
      cur = slot_r[0];
    end else if (mask_r[1]) begin
      sel[1] = 1'b1;
      cur = slot_r[1];
    end else if (mask_r[2]) begin
      sel[2] = 1'b1;
      cur = slot_r[2];
    end else if (mask_r[3]) begin
      sel[3] = 1'b1;
      cur = slot_r[3];
    end
  end

  assign out_tvalid = |mask_r;
  assign out_tlast = (mask_r == sel);
  assign out_tdata = {cur.run, cur.data};
  assign take = out_tvalid && out_tready;
  assign free = !out_tvalid || (take && out_tlast);

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = batch.valid;
    end else if (take) begin
      mask_nxt = mask_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= batch.slot;
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:8] != '0)
    else $error("result with zero run length");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_tlast) |=> out_tvalid)
    else $error("results of an item lost before its last one");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_tlast && !load) |=> !out_tvalid)
    else $error("result invented after the last one of an item");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_tvalid || (take && out_tlast)))
    else $error("new item loaded over pending results");

endmodule
`default_nettype wire

// ===== src/text_line_end_and_tab_normalizer.sv =====
// The first result of an item is presented in the cycle after the item is accepted.
// Throughput: one item per cycle while each item gives at most one result and out_tready
// is high; an item with up to four results holds the result register until the last is
// taken, one per cycle while out_tready is high. Reset (rst_n low, synchronous) clears the
// columns and the result register and sets insert_cr 0, compress_tabs 1, ensure_eof 0.
`default_nettype none
module text_line_end_and_tab_normalizer
  import tln_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // data_byte [7:0]
  input  wire logic        in_tlast,    // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // out_byte [7:0], run_length [23:8]
  output logic             out_tlast,   // last_result
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);

  logic insert_cr_r, compress_tabs_r, ensure_eof_r;
  col_t wcol_r, wcol_nxt, ecol_r, ecol_nxt;
  logic accept;
  batch_t batch;

  logic is_lf, is_other, tab_ok, eof_drop;
  col_t tabs, e_after, spaces;
  logic [COL_BITS:0] e_plus1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insert_cr_r <= 1'b0;
      compress_tabs_r <= 1'b1;
      ensure_eof_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INSERT_CR:     insert_cr_r <= cfg_data;
        CFG_COMPRESS_TABS: compress_tabs_r <= cfg_data;
        CFG_ENSURE_EOF:    ensure_eof_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  always_comb begin
    is_lf = (in_tdata == CH_LF);
    is_other = (in_tdata != CH_LF) && (in_tdata != CH_SP) &&
               (in_tdata != CH_TAB) && (in_tdata != CH_CR);
    // The emitted column never passes the wanted one, so these differences are safe.
    e_plus1 = {1'b0, ecol_r} + (COL_BITS+1)'(1);
    tabs = (wcol_r >> 3) - (ecol_r >> 3);
    tab_ok = compress_tabs_r && (e_plus1 < {1'b0, wcol_r}) && (tabs != '0);
    e_after = tab_ok ? {wcol_r[COL_BITS-1:3], 3'b000} : ecol_r;
    spaces = wcol_r - e_after;
    eof_drop = in_tlast && (in_tdata == CH_EOF) && !ensure_eof_r;

    batch.slot[0].data = is_lf ? CH_CR : CH_TAB;
    batch.slot[0].run = is_lf ? RUN_ONE : sat_run(tabs);
    batch.valid[0] = is_lf ? insert_cr_r : (is_other && tab_ok);
    batch.slot[1].data = is_lf ? CH_LF : CH_SP;
    batch.slot[1].run = is_lf ? RUN_ONE : sat_run(spaces);
    batch.valid[1] = is_lf || (is_other && (wcol_r > e_after));
    batch.slot[2].data = in_tdata;
    batch.slot[2].run = RUN_ONE;
    batch.valid[2] = is_other && !eof_drop;
    batch.slot[3].data = CH_EOF;
    batch.slot[3].run = RUN_ONE;
    batch.valid[3] = in_tlast && ensure_eof_r && (in_tdata != CH_EOF);
  end

  always_comb begin
    wcol_nxt = wcol_r;
    ecol_nxt = ecol_r;
    case (in_tdata)
      CH_SP: wcol_nxt = inc_sat(wcol_r);
      CH_TAB: wcol_nxt = inc_sat(wcol_r | col_t'(7));
      CH_CR: ;
      CH_LF: begin
        wcol_nxt = '0;
        ecol_nxt = '0;
      end
      default: begin
        wcol_nxt = inc_sat(wcol_r);
        ecol_nxt = inc_sat(wcol_r);
      end
    endcase
    if (in_tlast) begin
      wcol_nxt = '0;
      ecol_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r <= '0;
      ecol_r <= '0;
    end else if (accept) begin
      wcol_r <= wcol_nxt;
      ecol_r <= ecol_nxt;
    end
  end

  tln_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .batch      (batch),
    .free       (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== bench/text_line_end_checker.sv =====
module text_line_end_checker
  import tln_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // data_byte [7:0]
  input  wire logic        in_tlast,    // end_of_text
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,   // out_byte [7:0], run_length [23:8]
  input  wire logic        out_tlast,   // last_result
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,
  output int unsigned      pending,
  output int unsigned      checked,
  output int unsigned      fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam col_t TAB_STOP_MASK = col_t'(7);

  typedef struct packed {
    byte_t data;
    run_t  run;
    logic  last;
  } run_item_t;

  run_item_t expected_runs[$];
  run_item_t item_runs[$];

  logic insert_cr;
  logic compress_tabs;
  logic ensure_eof;
  col_t want_col;
  col_t emit_col;
  int unsigned errors;
  int unsigned results_seen;

  function automatic col_t col_sat(input logic [COL_BITS:0] v);
    return (v > {1'b0, COL_MAX}) ? COL_MAX : col_t'(v);
  endfunction

  // Collects the runs caused by the current item; a run of zero emits nothing.
  function void add_run(input byte_t data, input col_t count);
    run_item_t r;
    if (count != '0 && item_runs.size() < SLOTS) begin
      r.data = data;
      r.run = (count > RUN_MAX) ? RUN_MAX : run_t'(count);
      r.last = 1'b0;
      item_runs.push_back(r);
    end
  endfunction

  task automatic normalise_byte(input byte_t b, input logic eot);
    col_t w;
    col_t e;
    col_t tabs;
    item_runs.delete();
    if (b == CH_SP) begin
      want_col = col_sat({1'b0, want_col} + 1'b1);
    end else if (b == CH_TAB) begin
      want_col = col_sat({1'b0, want_col | TAB_STOP_MASK} + 1'b1);
    end else if (b == CH_LF) begin
      if (insert_cr) begin
        add_run(CH_CR, col_t'(1));
      end
      add_run(CH_LF, col_t'(1));
      want_col = '0;
      emit_col = '0;
    end else if (b != CH_CR) begin
      w = want_col;
      e = emit_col;
      // Tabs only pay off when at least two columns are pending.
      if (compress_tabs && ({1'b0, e} + 1'b1 < {1'b0, w})) begin
        tabs = (w >> 3) - (e >> 3);
        if (tabs != '0) begin
          add_run(CH_TAB, tabs);
          e = w & ~TAB_STOP_MASK;
        end
      end
      if (w > e) begin
        add_run(CH_SP, w - e);
      end
      // A Ctrl-Z that ends the text is swallowed unless end markers are enforced.
      if (!(eot && b == CH_EOF && !ensure_eof)) begin
        add_run(b, col_t'(1));
      end
      want_col = col_sat({1'b0, want_col} + 1'b1);
      emit_col = want_col;
    end
    if (eot) begin
      if (ensure_eof && b != CH_EOF) begin
        add_run(CH_EOF, col_t'(1));
      end
      want_col = '0;
      emit_col = '0;
    end
    if (item_runs.size() > 0) begin
      item_runs[item_runs.size()-1].last = 1'b1;
    end
    foreach (item_runs[i]) begin
      expected_runs.push_back(item_runs[i]);
    end
  endtask

  always @(posedge clk) begin : monitor
    run_item_t want;
    if (!rst_n) begin
      insert_cr = 1'b0;
      compress_tabs = 1'b1;
      ensure_eof = 1'b0;
      want_col = '0;
      emit_col = '0;
      expected_runs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INSERT_CR:     insert_cr = cfg_data;
          CFG_COMPRESS_TABS: compress_tabs = cfg_data;
          CFG_ENSURE_EOF:    ensure_eof = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        normalise_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_runs.size() == 0) begin
          $error("result with nothing expected: out_byte %02h run_length %0d last_result %0b",
                 out_tdata[7:0], out_tdata[23:8], out_tlast);
          errors++;
        end else begin
          want = expected_runs.pop_front();
          if (out_tdata[7:0] !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[23:8] !== want.run) begin
            $error("run_length: expected %0d, got %0d", want.run, out_tdata[23:8]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
        end
      end
    end
    pending <= expected_runs.size();
    checked <= results_seen;
    fail_count <= errors;
  end

  initial begin
    errors = 0;
    results_seen = 0;
  end

endmodule

// ===== bench/tb_text_line_end_and_tab_normalizer.sv =====
module tb_text_line_end_and_tab_normalizer;
  import tln_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // data_byte [7:0]
  logic        in_tlast;    // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // out_byte [7:0], run_length [23:8]
  logic        out_tlast;   // last_result
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic        cfg_data;

  int unsigned pending;
  int unsigned checked;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned settings_used;
  bit          hold_req;

  text_line_end_and_tab_normalizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  text_line_end_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .checked    (checked),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input byte_t b, input logic last);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The first check waits for the next edge, so the last accepted item is already counted.
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register, then an unused index that the block must ignore.
  task automatic set_config(input logic cr, input logic tabs, input logic eof);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INSERT_CR;
    cfg_data <= cr;
    @(posedge clk);
    cfg_index <= CFG_COMPRESS_TABS;
    cfg_data <= tabs;
    @(posedge clk);
    cfg_index <= CFG_ENSURE_EOF;
    cfg_data <= eof;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= !tabs;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly lines of words separated by blanks, with some raw bytes mixed in.
  task automatic run_text_phase(input int count, input bit drain_midway);
    int burst_left;
    int pick;
    byte_t b;
    logic eot;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        b = byte_t'($urandom_range(8'h21, 8'h7E));
      end else if (pick < 60) begin
        b = CH_SP;
      end else if (pick < 70) begin
        b = CH_TAB;
      end else if (pick < 80) begin
        b = CH_LF;
      end else if (pick < 85) begin
        b = CH_CR;
      end else if (pick < 89) begin
        b = CH_EOF;
      end else begin
        b = byte_t'($urandom_range(0, 255));
      end
      eot = ($urandom_range(0, 24) == 0);
      if (eot && $urandom_range(0, 9) < 4) begin
        b = CH_EOF;
      end
      send_item(b, eot);
      if (drain_midway && i == count / 2) begin
        drain_and_settle();
      end
      burst_left--;
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // Receiver: ready patterns of random length, plus one long hold-off on request.
  initial begin
    int mode;
    int span;
    int tick;
    out_tready <= 1'b0;
    mode = 0;
    span = 20;
    tick = 0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((tick % 5) < 2);
        endcase
        @(posedge clk);
        tick++;
        span--;
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 60);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_text_line_end_and_tab_normalizer: FAIL");
    $finish;
  end

  initial begin
    items_sent = 0;
    settings_used = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INSERT_CR;
    cfg_data <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: no CR, tab compression, trailing Ctrl-Z removed.
    send_item(CH_SP, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item("A", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item("B", 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_EOF, 1'b1);
    send_item(CH_EOF, 1'b1);
    drain_and_settle();

    set_config(1'b1, 1'b1, 1'b1);
    send_item(CH_SP, 1'b0);
    send_item("C", 1'b0);
    send_item(CH_LF, 1'b1);
    send_item(CH_TAB, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item(CH_SP, 1'b0);
    send_item("D", 1'b1);
    send_item(CH_EOF, 1'b1);
    send_item(CH_SP, 1'b1);
    drain_and_settle();

    set_config(1'b0, 1'b0, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item("E", 1'b1);
    drain_and_settle();

    for (int phase = 0; phase < 4; phase++) begin
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      run_text_phase(48, phase == 2);
      drain_and_settle();
    end

    $display("Covered %0d items and %0d checked results under %0d register settings,",
             items_sent, checked, settings_used);
    $display("including line ends, tab and space padding, end markers and a long stall.");
    if (fail_count == 0) begin
      $display("tb_text_line_end_and_tab_normalizer: PASS");
    end else begin
      $display("tb_text_line_end_and_tab_normalizer: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tln_pkg.sv
src/tln_emit.sv
src/text_line_end_and_tab_normalizer.sv
bench/text_line_end_checker.sv
bench/tb_text_line_end_and_tab_normalizer.sv
